FILE: hdl/dtmf_pkg.sv
// Shared constants, payload types and the quarter-wave sine table of the DTMF tone generator.
// No dependencies; used by the interfaces, the top level and the checker.
package dtmf_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int PHASE_BITS      = 32;

	localparam int NUM_TONES  = 8;
	localparam int TONE_IDX_W = $clog2(NUM_TONES);
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam int KEY_W      = 8;
	localparam int SAMPLE_W   = 31;
	localparam int SINE_W     = 30;
	localparam int MAG_W      = 29;

	// quarter wave plus the peak entry
	localparam int QTAB_N = (1 << (SINE_TABLE_BITS - 2)) + 1;

	localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
	localparam logic [63:0] AMP_SCALE   = 64'd1073741823;
	localparam logic [63:0] LOW32       = 64'hFFFFFFFF;

	localparam logic [31:0] STEP_RESET [NUM_TONES] = '{
		32'd62366504,  32'd68898434,  32'd76235670,  32'd84199255,
		32'd108179489, 32'd119542256, 32'd132159723, 32'd146118367
	};

	typedef logic [KEY_W-1:0]           key_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [MAG_W-1:0]           qsine_tab_t [QTAB_N];

	// low 64 bits of (a*b) >> 60
	function automatic logic [63:0] mul_sh60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// Taylor series of the angle in Q4.60, evaluated at elaboration only
	function automatic qsine_tab_t build_qsine();
		qsine_tab_t   tab;
		logic [127:0] p;
		logic [63:0]  x, x2, term, sum, mag;
		for (int j = 0; j < QTAB_N; j++) begin
			if (j == 0) begin
				tab[j] = '0;
			end else begin
				p = {64'd0, HALF_PI_Q60} * 128'(j);
				x = 64'(p >> (SINE_TABLE_BITS - 2));
				x2 = mul_sh60(x, x);
				term = x;
				sum = x;
				term = mul_sh60(term, x2) / 64'd6;   sum = sum - term;
				term = mul_sh60(term, x2) / 64'd20;  sum = sum + term;
				term = mul_sh60(term, x2) / 64'd42;  sum = sum - term;
				term = mul_sh60(term, x2) / 64'd72;  sum = sum + term;
				term = mul_sh60(term, x2) / 64'd110; sum = sum - term;
				term = mul_sh60(term, x2) / 64'd156; sum = sum + term;
				term = mul_sh60(term, x2) / 64'd210; sum = sum - term;
				term = mul_sh60(term, x2) / 64'd272; sum = sum + term;
				term = mul_sh60(term, x2) / 64'd342; sum = sum - term;
				term = mul_sh60(term, x2) / 64'd420; sum = sum + term;
				term = mul_sh60(term, x2) / 64'd506; sum = sum - term;
				term = mul_sh60(term, x2) / 64'd600; sum = sum + term;
				term = mul_sh60(term, x2) / 64'd702; sum = sum - term;
				term = mul_sh60(term, x2) / 64'd812; sum = sum + term;
				term = mul_sh60(term, x2) / 64'd930; sum = sum - term;
				mag = ((sum >> 32) * AMP_SCALE + (((sum & LOW32) * AMP_SCALE) >> 32)) >> 29;
				tab[j] = mag[MAG_W-1:0];
			end
		end
		return tab;
	endfunction

	localparam qsine_tab_t QSINE = build_qsine();

endpackage

FILE: hdl/dtmf_if.sv
// Valid/ready channel interfaces: key requests in, stereo sample requests out.
// Depends on dtmf_pkg for payload types.
interface dtmf_key_if;
	logic          valid;
	logic          ready;
	dtmf_pkg::key_t left_key;
	dtmf_pkg::key_t right_key;

	modport source (output valid, output left_key, output right_key, input ready);
	modport sink   (input valid, input left_key, input right_key, output ready);
endinterface

interface dtmf_smp_if;
	logic              valid;
	logic              ready;
	dtmf_pkg::sample_t left_sample;
	dtmf_pkg::sample_t right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

FILE: hdl/dtmf_stereo_tone_generator.sv
// Stereo DTMF tone generator: eight phase accumulators, key decode, quarter-wave sine lookup.
// Depends on dtmf_pkg and the channel interfaces in dtmf_if.sv.
// Pipeline: s1 decodes the accepted key request, s2 does the lookup/add and drives the sample request.
// Throughput: one request per cycle; stalls only while both stages hold and out is not ready.
// Reset (arst_n low, async): phases zero, steps to their nominal tone values, pipe empty.
module dtmf_stereo_tone_generator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dtmf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dtmf_pkg::CFG_DATA_W-1:0]  cfg_data,
	dtmf_key_if.sink                         key_in,
	dtmf_smp_if.source                       smp_out
);

	localparam int STB       = dtmf_pkg::SINE_TABLE_BITS;
	localparam int PB        = dtmf_pkg::PHASE_BITS;
	localparam int TONE_BITS = dtmf_pkg::TONE_IDX_W;

	// per channel: which tones sound and the table address of each
	typedef struct packed {
		logic           row_hit;
		logic [STB-1:0] row_ph;
		logic           col_hit;
		logic [STB-1:0] col_ph;
	} chan_sel_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] idx;
	} tone_sel_t;

	// Accumulators and steps, tone order matches the register list
	logic [PB-1:0] phase_q [dtmf_pkg::NUM_TONES];
	logic [PB-1:0] step_q  [dtmf_pkg::NUM_TONES];

	logic      vld_s1, vld_s2;
	logic      rdy_s1, rdy_s2;
	chan_sel_t left_s1, right_s1;
	dtmf_pkg::sample_t left_smp_s2, right_smp_s2;

	// Row group: 697/770/852/941 Hz
	function automatic tone_sel_t row_of(input dtmf_pkg::key_t key);
		tone_sel_t r;
		r.hit = 1'b1;
		unique case (key)
			"1", "2", "3", "A": r.idx = 2'd0;
			"4", "5", "6", "B": r.idx = 2'd1;
			"7", "8", "9", "C": r.idx = 2'd2;
			"*", "0", "#", "D": r.idx = 2'd3;
			default: begin
				r.hit = 1'b0;
				r.idx = 2'd0;
			end
		endcase
		return r;
	endfunction

	// Column group: 1209/1336/1477/1633 Hz
	function automatic tone_sel_t col_of(input dtmf_pkg::key_t key);
		tone_sel_t c;
		c.hit = 1'b1;
		unique case (key)
			"1", "4", "7", "*": c.idx = 2'd0;
			"2", "5", "8", "0": c.idx = 2'd1;
			"3", "6", "9", "#": c.idx = 2'd2;
			"A", "B", "C", "D": c.idx = 2'd3;
			default: begin
				c.hit = 1'b0;
				c.idx = 2'd0;
			end
		endcase
		return c;
	endfunction

	// Table address of a tone: top bits of its phase before this tick's advance
	function automatic logic [STB-1:0] tone_addr(input logic [TONE_BITS-1:0] t);
		return phase_q[t][PB-1 -: STB];
	endfunction

	function automatic chan_sel_t decode(input dtmf_pkg::key_t key);
		chan_sel_t s;
		tone_sel_t r, c;
		r = row_of(key);
		c = col_of(key);
		s.row_hit = r.hit;
		s.row_ph  = tone_addr({1'b0, r.idx});
		s.col_hit = c.hit;
		s.col_ph  = tone_addr({1'b1, c.idx});
		return s;
	endfunction

	// Full-cycle sine from the quarter table: mirror in the quarter, negate in the second half
	function automatic logic signed [dtmf_pkg::SINE_W-1:0] sine_at(input logic [STB-1:0] addr);
		logic           neg;
		logic [STB-2:0] k;
		logic [STB-1:0] fold;
		logic [STB-2:0] j;
		logic signed [dtmf_pkg::SINE_W-1:0] mag;
		neg  = addr[STB-1];
		k    = addr[STB-2:0];
		fold = {1'b1, {(STB-1){1'b0}}} - {1'b0, k};
		if ({1'b0, k} <= {2'b01, {(STB-2){1'b0}}})
			j = k;
		else
			j = fold[STB-2:0];
		mag = $signed({1'b0, dtmf_pkg::QSINE[j]});
		return neg ? -mag : mag;
	endfunction

	function automatic dtmf_pkg::sample_t chan_sum(input chan_sel_t s);
		logic signed [dtmf_pkg::SINE_W-1:0] r, c;
		r = s.row_hit ? sine_at(s.row_ph) : '0;
		c = s.col_hit ? sine_at(s.col_ph) : '0;
		return dtmf_pkg::SAMPLE_W'(r) + dtmf_pkg::SAMPLE_W'(c);
	endfunction

	// Two-stage pipe; an empty s1 still takes a key while a finished sample waits in s2
	assign rdy_s2       = !vld_s2 || smp_out.ready;
	assign rdy_s1       = !vld_s1 || rdy_s2;
	assign key_in.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int i = 0; i < dtmf_pkg::NUM_TONES; i++) begin
				phase_q[i] <= '0;
				step_q[i]  <= dtmf_pkg::STEP_RESET[i][PB-1:0];
			end
		end else begin
			// user must change steps only while idle (unchecked); drops index 8 and up
			if (cfg_we && cfg_index < dtmf_pkg::CFG_IDX_W'(dtmf_pkg::NUM_TONES)) begin
				step_q[cfg_index[TONE_BITS-1:0]] <= cfg_data[PB-1:0];
			end
			if (rdy_s1) begin
				vld_s1 <= key_in.valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			// every accepted tick advances all eight tones, keyed or not
			if (key_in.valid && rdy_s1) begin
				for (int i = 0; i < dtmf_pkg::NUM_TONES; i++) begin
					phase_q[i] <= phase_q[i] + step_q[i];
				end
			end
		end
	end

	// Payload registers, no reset
	always_ff @(posedge clk) begin
		if (key_in.valid && rdy_s1) begin
			left_s1  <= decode(key_in.left_key);
			right_s1 <= decode(key_in.right_key);
		end
		if (vld_s1 && rdy_s2) begin
			left_smp_s2  <= chan_sum(left_s1);
			right_smp_s2 <= chan_sum(right_s1);
		end
	end

	assign smp_out.valid        = vld_s2;
	assign smp_out.left_sample  = left_smp_s2;
	assign smp_out.right_sample = right_smp_s2;

endmodule

FILE: hdl/dtmf_chk.sv
// Port-level checker for the DTMF tone generator, attached by bind.
// Depends on dtmf_pkg and the channel interfaces in dtmf_if.sv.
module dtmf_chk (
	input logic        clk,
	input logic        arst_n,
	dtmf_key_if.sink   key_in,
	dtmf_smp_if.source smp_out
);

	localparam dtmf_pkg::sample_t SMP_MAX = dtmf_pkg::SAMPLE_W'(1073741822);
	localparam dtmf_pkg::sample_t SMP_MIN = dtmf_pkg::SAMPLE_W'(-1073741822);

	// stalled sample request holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		smp_out.valid && !smp_out.ready |=> smp_out.valid
			&& $stable(smp_out.left_sample) && $stable(smp_out.right_sample))
		else $error("sample request changed while stalled");

	// input back-pressure only comes from a full pipe behind a stalled output
	a_bp_source: assert property (@(posedge clk) disable iff (!arst_n)
		!key_in.ready |-> smp_out.valid && !smp_out.ready)
		else $error("key input stalled without output back-pressure");

	// sum of two half-scale tones stays in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		smp_out.valid |-> smp_out.left_sample <= SMP_MAX && smp_out.left_sample >= SMP_MIN
			&& smp_out.right_sample <= SMP_MAX && smp_out.right_sample >= SMP_MIN)
		else $error("sample out of range");

	// pipe leaves reset empty
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !smp_out.valid)
		else $error("sample valid coming out of reset");

endmodule

bind dtmf_stereo_tone_generator dtmf_chk u_dtmf_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.key_in  (key_in),
	.smp_out (smp_out)
);

FILE: tb/sv/tb_dtmf_stereo_tone_generator.sv
`timescale 1ns / 100ps
// Self-checking testbench for the stereo DTMF tone generator: key requests in, sample requests out.
// Depends on dtmf_pkg and the channel interfaces in dtmf_if.sv; holds its own tone predictor.
module tb_dtmf_stereo_tone_generator;

	// pipe is two stages deep; wait_idle covers it after the last sample
	localparam int LATENCY     = 2;
	localparam int STALL_LIMIT = 2000;
	localparam int NO_TONE     = dtmf_pkg::NUM_TONES;
	localparam int HALF_TAB    = 1 << (dtmf_pkg::SINE_TABLE_BITS - 1);
	localparam int RAND_ITEMS  = 100;

	// pi/2 in unsigned Q4.60, truncated
	localparam logic [63:0] QUARTER_TURN_Q60 = 64'h1921FB54442D1846;
	localparam logic [63:0] FULL_SCALE       = 64'd1073741823;

	// step register indexes, also the tone order of the accumulators
	typedef enum int {
		STEP_ROW_697, STEP_ROW_770, STEP_ROW_852, STEP_ROW_941,
		STEP_COL_1209, STEP_COL_1336, STEP_COL_1477, STEP_COL_1633
	} step_reg_e;

	localparam logic [31:0] NOMINAL_STEP [dtmf_pkg::NUM_TONES] = '{
		32'd62366504,  32'd68898434,  32'd76235670,  32'd84199255,
		32'd108179489, 32'd119542256, 32'd132159723, 32'd146118367
	};

	localparam dtmf_pkg::key_t DTMF_KEYS [16] = '{
		"1", "2", "3", "A", "4", "5", "6", "B",
		"7", "8", "9", "C", "*", "0", "#", "D"
	};

	// bytes that look close to keys but are not: controls, lowercase, neighbors in ASCII
	localparam dtmf_pkg::key_t NON_KEYS [10] = '{
		8'h00, 8'hFF, "a", "d", "/", ":", "@", "E", 8'h7F, "e"
	};

	typedef struct packed {
		dtmf_pkg::sample_t left;
		dtmf_pkg::sample_t right;
	} stereo_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [dtmf_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dtmf_pkg::CFG_DATA_W-1:0] cfg_data;

	dtmf_key_if key_ch();
	dtmf_smp_if smp_ch();

	dtmf_stereo_tone_generator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key_in    (key_ch),
		.smp_out   (smp_ch)
	);

	// predictor state: accumulators and steps as the block should hold them
	logic [dtmf_pkg::PHASE_BITS-1:0] phase_acc [dtmf_pkg::NUM_TONES];
	logic [31:0]                     step_val [dtmf_pkg::NUM_TONES];
	stereo_t                         pending_samples [$];

	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Tone predictor
	// ------------------------------------------------------------------

	// One full-cycle sine entry: Taylor series in Q4.60 on the folded quarter-wave
	// angle, truncation at every product and divide, then scaled to the 30-bit
	// amplitude. The top index bit selects the negative half cycle.
	function automatic int sine_value(logic [dtmf_pkg::SINE_TABLE_BITS-1:0] idx);
		logic [127:0] prod;
		logic [63:0]  x, x_sq, term, acc, mag;
		int           k, j;
		k = int'(idx[dtmf_pkg::SINE_TABLE_BITS-2:0]);
		j = (k <= HALF_TAB / 2) ? k : HALF_TAB - k;
		if (j == 0)
			return 0;
		prod = {64'd0, QUARTER_TURN_Q60} * 128'(j);
		x = prod[dtmf_pkg::SINE_TABLE_BITS-2 +: 64];
		prod = {64'd0, x} * {64'd0, x};
		x_sq = prod[60 +: 64];
		term = x;
		acc = x;
		for (int n = 2; n <= 30; n += 2) begin
			prod = {64'd0, term} * {64'd0, x_sq};
			term = prod[60 +: 64] / 64'(n * (n + 1));
			if (n % 4 == 2)
				acc = acc - term;
			else
				acc = acc + term;
		end
		mag = ((acc >> 32) * FULL_SCALE + (((acc & 64'hFFFF_FFFF) * FULL_SCALE) >> 32)) >> 29;
		return idx[dtmf_pkg::SINE_TABLE_BITS-1] ? -int'(mag) : int'(mag);
	endfunction

	function automatic int key_row(dtmf_pkg::key_t k);
		case (k)
			"1", "2", "3", "A": return STEP_ROW_697;
			"4", "5", "6", "B": return STEP_ROW_770;
			"7", "8", "9", "C": return STEP_ROW_852;
			"*", "0", "#", "D": return STEP_ROW_941;
			default:            return NO_TONE;
		endcase
	endfunction

	function automatic int key_col(dtmf_pkg::key_t k);
		case (k)
			"1", "4", "7", "*": return STEP_COL_1209;
			"2", "5", "8", "0": return STEP_COL_1336;
			"3", "6", "9", "#": return STEP_COL_1477;
			"A", "B", "C", "D": return STEP_COL_1633;
			default:            return NO_TONE;
		endcase
	endfunction

	// unknown key: that tone adds nothing
	function automatic int tone_level(int t);
		if (t == NO_TONE)
			return 0;
		return sine_value(phase_acc[t][dtmf_pkg::PHASE_BITS-1 -: dtmf_pkg::SINE_TABLE_BITS]);
	endfunction

	// sample pair from the phases before this tick, then all eight tones advance
	function automatic void predict_stereo(dtmf_pkg::key_t lk, dtmf_pkg::key_t rk);
		stereo_t s;
		s.left = dtmf_pkg::sample_t'(tone_level(key_row(lk)) + tone_level(key_col(lk)));
		s.right = dtmf_pkg::sample_t'(tone_level(key_row(rk)) + tone_level(key_col(rk)));
		pending_samples.push_back(s);
		for (int t = 0; t < dtmf_pkg::NUM_TONES; t++)
			phase_acc[t] = phase_acc[t] + step_val[t][dtmf_pkg::PHASE_BITS-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// sample side back-pressure, redrawn each cycle
	initial begin
		smp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			smp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// One key request. Idle gaps first (valid low), then hold valid until the
	// block takes it; the prediction is made at the accepting edge.
	task automatic send_keys(dtmf_pkg::key_t lk, dtmf_pkg::key_t rk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			key_ch.valid <= 1'b0;
		end
		@(negedge clk);
		key_ch.valid <= 1'b1;
		key_ch.left_key <= lk;
		key_ch.right_key <= rk;
		do
			@(posedge clk);
		while (key_ch.ready !== 1'b1);
		predict_stereo(lk, rk);
	endtask

	task automatic write_step(int idx, logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= dtmf_pkg::CFG_IDX_W'(idx);
		cfg_data <= value;
		@(posedge clk);
		if (idx < dtmf_pkg::NUM_TONES)
			step_val[idx] = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// drop valid, let every expected sample come back, then cover the pipe
	task automatic wait_idle();
		@(negedge clk);
		key_ch.valid <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	function automatic dtmf_pkg::key_t pick_key();
		if ($urandom_range(0, 99) < 85)
			return DTMF_KEYS[$urandom_range(0, 15)];
		return dtmf_pkg::key_t'($urandom_range(0, 255));
	endfunction

	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h8000_0000;
			3:       return 32'($urandom_range(0, (1 << dtmf_pkg::SINE_TABLE_BITS) - 1))
					<< (dtmf_pkg::PHASE_BITS - dtmf_pkg::SINE_TABLE_BITS);
			4, 5:    return 32'($urandom_range(50_000_000, 150_000_000));
			default: return $urandom;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Checker and watchdog
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		stereo_t want;
		if (arst_n && smp_ch.valid === 1'b1 && smp_ch.ready === 1'b1) begin
			if (pending_samples.size() == 0) begin
				$display("%0t: sample request with none expected, left %0d right %0d",
					$time, smp_ch.left_sample, smp_ch.right_sample);
				errors++;
			end else begin
				want = pending_samples.pop_front();
				if (smp_ch.left_sample !== want.left) begin
					$display("%0t: left_sample expected %0d actual %0d",
						$time, want.left, smp_ch.left_sample);
					errors++;
				end
				if (smp_ch.right_sample !== want.right) begin
					$display("%0t: right_sample expected %0d actual %0d",
						$time, want.right, smp_ch.right_sample);
					errors++;
				end
			end
		end
	end

	// no request moving on either side for too long means the block hung
	always @(posedge clk) begin
		if ((key_ch.valid === 1'b1 && key_ch.ready === 1'b1)
				|| (smp_ch.valid === 1'b1 && smp_ch.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Nominal steps from reset. Every key on the left once; the right side
	// alternates mirrored keys and non-keys, and two ticks put a non-key left.
	task automatic test_key_decode();
		for (int i = 0; i < 16; i++) begin
			if (i % 2 == 0)
				send_keys(DTMF_KEYS[i], DTMF_KEYS[15-i]);
			else
				send_keys(DTMF_KEYS[i], NON_KEYS[i/2]);
		end
		send_keys(NON_KEYS[8], "5");
		send_keys(NON_KEYS[9], "D");
	endtask

	// zero step freezes every tone, all-ones walks backwards by one, the
	// half-turn step flips the sign of the sine each tick
	task automatic test_step_extremes();
		logic [31:0] settings [3];
		settings = '{32'd0, 32'hFFFF_FFFF, 32'h8000_0000};
		foreach (settings[s]) begin
			wait_idle();
			for (int t = 0; t < dtmf_pkg::NUM_TONES; t++)
				write_step(t, settings[s]);
			repeat (2) send_keys(pick_key(), pick_key());
		end
	endtask

	// indexes past the last step register must leave the steps alone
	task automatic test_ignored_index();
		wait_idle();
		for (int t = 0; t < dtmf_pkg::NUM_TONES; t++)
			write_step(t, 32'h4000_0000);
		for (int i = dtmf_pkg::NUM_TONES; i < (1 << dtmf_pkg::CFG_IDX_W); i++)
			write_step(i, $urandom);
		repeat (3) send_keys(pick_key(), pick_key());
	endtask

	// random steps and keys under each mix of input idling and output stalls
	task automatic test_random_traffic();
		int idle_mix [4];
		int stall_mix [4];
		idle_mix = '{0, 50, 0, 31};
		stall_mix = '{0, 0, 50, 31};
		for (int p = 0; p < 4; p++) begin
			wait_idle();
			for (int t = 0; t < dtmf_pkg::NUM_TONES; t++)
				write_step(t, pick_step());
			send_idle_pct = idle_mix[p];
			recv_stall_pct = stall_mix[p];
			repeat (RAND_ITEMS) send_keys(pick_key(), pick_key());
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		key_ch.valid = 1'b0;
		key_ch.left_key = '0;
		key_ch.right_key = '0;
		for (int t = 0; t < dtmf_pkg::NUM_TONES; t++) begin
			phase_acc[t] = '0;
			step_val[t] = NOMINAL_STEP[t];
		end
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_key_decode();
		test_step_extremes();
		test_ignored_index();
		test_random_traffic();

		// the watchdog bounds this wait
		wait_idle();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
